FILE: hw/rtl/mcgr_pkg.sv
`default_nettype none

package mcgr_pkg;

  // Field widths
  localparam int CRD_W     = 24;  // coordinates and centre, 1/256 A
  localparam int NRM_W     = 16;  // normal components, Q2.14
  localparam int THK_W     = 23;  // core thickness
  localparam int FRAC_W    = 14;  // fraction bits of the normal
  localparam int CW        = 26;  // collapsed coordinate
  localparam int DOT_W     = 42;  // dot product of normal and offset
  localparam int MOV_W     = 24;  // clamped plane distance
  localparam int SQ_W      = 64;  // wrapping sum of squares
  localparam int RG_W      = 40;  // result
  localparam int PC_W      = 13;  // reported point count
  localparam int MUL_W     = 34;  // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_CNT_W = $clog2(RG_W);

  // Configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_ENABLE = 4'd7;

  localparam logic signed [NRM_W-1:0] NORMAL_Z_RESET = 16'sd16384;

  typedef struct packed {
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic signed [CRD_W-1:0] center_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [THK_W-1:0]        core_thickness;
    logic                    membrane_enable;
  } cfg_t;

  // One classified point on its way from the front to the back end
  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic                    accum;
    logic                    last;
  } item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mcgr_queue.sv
`default_nettype none

module mcgr_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  mcgr_pkg::item_t      item_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 empty_o,
  output mcgr_pkg::item_t      item_o
);
  import mcgr_pkg::*;

  // Two-entry FIFO between front and back end.
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcgr_front.sv
`default_nettype none

module mcgr_front #(
  parameter int MAX_POINTS = 4096
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire signed [mcgr_pkg::CRD_W-1:0]  coord_x_i,
  input  wire signed [mcgr_pkg::CRD_W-1:0]  coord_y_i,
  input  wire signed [mcgr_pkg::CRD_W-1:0]  coord_z_i,
  input  wire                               coord_valid_i,
  input  wire                               last_i,
  input  wire                               full_i,
  output logic                              push_o,
  output mcgr_pkg::item_t                   item_o
);
  import mcgr_pkg::*;

  localparam int CNTW = $clog2(MAX_POINTS + 1);

  // Count of points admitted to the current set, so that points past the
  // limit are marked as skipped before they reach the back end.
  logic [CNTW-1:0] cnt_q;
  logic            accum;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign accum      = coord_valid_i && (cnt_q < CNTW'(MAX_POINTS));

  assign item_o = '{x: coord_x_i, y: coord_y_i, z: coord_z_i, accum: accum, last: last_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push_o) begin
      if (last_i) begin
        cnt_q <= '0;
      end else if (accum) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcgr_back.sv
`default_nettype none

module mcgr_back #(
  parameter int MAX_POINTS = 4096
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  mcgr_pkg::cfg_t                   cfg_i,
  input  wire                              empty_i,
  input  mcgr_pkg::item_t                  item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [mcgr_pkg::RG_W-1:0]        rg_squared_o,
  output logic [mcgr_pkg::PC_W-1:0]        point_count_o,
  output logic                             empty_res_o
);
  import mcgr_pkg::*;

  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SW   = CW + CNTW;
  localparam int H    = (SW + 1) / 2;
  localparam int WA   = CNTW + SQ_W + 1;
  localparam int WB   = 2 * SW + 2;
  localparam int WC   = 2 * CNTW + RG_W + 10;
  localparam int WAB  = (WA > WB) ? WA : WB;
  localparam int WW   = (WAB > WC) ? WAB : WC;

  localparam logic signed [DOT_W-1:0]  HALF_D = DOT_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) <<< (FRAC_W - 1);

  localparam logic [1:0] PART_LL   = 2'd0;
  localparam logic [1:0] PART_HL   = 2'd1;
  localparam logic [1:0] PART_HH   = 2'd2;
  localparam logic [1:0] PART_NONE = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_D0, ST_D1, ST_D2, ST_D3, ST_CL, ST_M0, ST_M1, ST_M2, ST_M3,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_FIN, ST_NQ0, ST_NQ1, ST_NQ2,
    ST_S2, ST_S2E, ST_DEN, ST_DEN2, ST_CMP, ST_SAT, ST_DIV, ST_OUT
  } state_e;

  state_e                  state_q;
  logic signed [CW-1:0]    x_q, y_q, z_q;
  logic                    last_q;
  logic signed [DOT_W-1:0] acc_q;
  logic signed [MOV_W-1:0] move_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [SW-1:0]    sx_q, sy_q, sz_q;
  logic [SQ_W-1:0]         sq_q;
  logic [CNTW-1:0]         cnt_q;
  logic [WW-1:0]           nq_q, s2_q, num_q, den_q, dv_q;
  logic [RG_W-1:0]         quo_q;
  logic [DIV_CNT_W-1:0]    bit_q;
  logic [1:0]              axis_q, part_q, ppart_q;
  logic                    emp_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0]        p_u;
  logic signed [PROD_W-1:0] p_rnd;
  logic signed [DOT_W-1:0]  plane_dist, thk_s;
  logic [SW-1:0]            mag_sel;
  logic [H-1:0]             mag_lo, mag_hi;
  logic [WW-1:0]            s2_add;
  logic                     coll_en, out_free;

  assign coll_en    = cfg_i.membrane_enable && (cfg_i.core_thickness != '0);
  assign out_free   = !out_valid_o || out_ready_i;
  assign pop_o      = (state_q == ST_IDLE) && !empty_i;
  assign p_u        = $unsigned(p_q);
  assign p_rnd      = (p_q + HALF_P) >>> FRAC_W;
  assign plane_dist = (acc_q + HALF_D) >>> FRAC_W;
  assign thk_s      = $signed({{(DOT_W - THK_W){1'b0}}, cfg_i.core_thickness});

  always_comb begin
    case (axis_q)
      AXIS_X:  mag_sel = (sx_q < 0) ? $unsigned(-sx_q) : $unsigned(sx_q);
      AXIS_Y:  mag_sel = (sy_q < 0) ? $unsigned(-sy_q) : $unsigned(sy_q);
      default: mag_sel = (sz_q < 0) ? $unsigned(-sz_q) : $unsigned(sz_q);
    endcase
  end

  assign mag_lo = mag_sel[H-1:0];
  assign mag_hi = H'(mag_sel[SW-1:H]);

  // Square of a sum magnitude as three partial products of half width
  always_comb begin
    case (ppart_q)
      PART_LL: s2_add = WW'(p_u);
      PART_HL: s2_add = WW'(p_u) << (H + 1);
      PART_HH: s2_add = WW'(p_u) << (2 * H);
      default: s2_add = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_D0: begin
        mul_a = MUL_W'(cfg_i.normal_x);
        mul_b = MUL_W'(x_q) - MUL_W'(cfg_i.center_x);
      end
      ST_D1: begin
        mul_a = MUL_W'(cfg_i.normal_y);
        mul_b = MUL_W'(y_q) - MUL_W'(cfg_i.center_y);
      end
      ST_D2: begin
        mul_a = MUL_W'(cfg_i.normal_z);
        mul_b = MUL_W'(z_q) - MUL_W'(cfg_i.center_z);
      end
      ST_M0: begin
        mul_a = MUL_W'(move_q);
        mul_b = MUL_W'(cfg_i.normal_x);
      end
      ST_M1: begin
        mul_a = MUL_W'(move_q);
        mul_b = MUL_W'(cfg_i.normal_y);
      end
      ST_M2: begin
        mul_a = MUL_W'(move_q);
        mul_b = MUL_W'(cfg_i.normal_z);
      end
      ST_SQ0: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(x_q);
      end
      ST_SQ1: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(y_q);
      end
      ST_SQ2: begin
        mul_a = MUL_W'(z_q);
        mul_b = MUL_W'(z_q);
      end
      ST_NQ0: begin
        mul_a = MUL_W'(cnt_q);
        mul_b = MUL_W'(sq_q[31:0]);
      end
      ST_NQ1: begin
        mul_a = MUL_W'(cnt_q);
        mul_b = MUL_W'(sq_q[63:32]);
      end
      ST_S2: begin
        case (part_q)
          PART_LL: begin
            mul_a = MUL_W'(mag_lo);
            mul_b = MUL_W'(mag_lo);
          end
          PART_HL: begin
            mul_a = MUL_W'(mag_hi);
            mul_b = MUL_W'(mag_lo);
          end
          default: begin
            mul_a = MUL_W'(mag_hi);
            mul_b = MUL_W'(mag_hi);
          end
        endcase
      end
      ST_DEN: begin
        mul_a = MUL_W'(cnt_q);
        mul_b = MUL_W'(cnt_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      x_q           <= '0;
      y_q           <= '0;
      z_q           <= '0;
      last_q        <= 1'b0;
      acc_q         <= '0;
      move_q        <= '0;
      p_q           <= '0;
      sx_q          <= '0;
      sy_q          <= '0;
      sz_q          <= '0;
      sq_q          <= '0;
      cnt_q         <= '0;
      nq_q          <= '0;
      s2_q          <= '0;
      num_q         <= '0;
      den_q         <= '0;
      dv_q          <= '0;
      quo_q         <= '0;
      bit_q         <= '0;
      axis_q        <= AXIS_X;
      part_q        <= PART_LL;
      ppart_q       <= PART_NONE;
      emp_q         <= 1'b0;
      out_valid_o   <= 1'b0;
      rg_squared_o  <= '0;
      point_count_o <= '0;
      empty_res_o   <= 1'b0;
    end else begin
      p_q <= mul_p;
      // In the output step a taken result is replaced by the next one below.
      if (out_valid_o && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            x_q    <= CW'(item_i.x);
            y_q    <= CW'(item_i.y);
            z_q    <= CW'(item_i.z);
            last_q <= item_i.last;
            if (item_i.accum) begin
              state_q <= coll_en ? ST_D0 : ST_SQ0;
            end else if (item_i.last) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_D0:  state_q <= ST_D1;
        ST_D1: begin
          acc_q   <= DOT_W'(p_q);
          state_q <= ST_D2;
        end
        ST_D2: begin
          acc_q   <= acc_q + DOT_W'(p_q);
          state_q <= ST_D3;
        end
        ST_D3: begin
          acc_q   <= acc_q + DOT_W'(p_q);
          state_q <= ST_CL;
        end
        ST_CL: begin
          if (plane_dist > thk_s) begin
            move_q <= MOV_W'(thk_s);
          end else if (plane_dist < -thk_s) begin
            move_q <= MOV_W'(-thk_s);
          end else begin
            move_q <= MOV_W'(plane_dist);
          end
          state_q <= ST_M0;
        end
        ST_M0:  state_q <= ST_M1;
        ST_M1: begin
          x_q     <= x_q - CW'(p_rnd);
          state_q <= ST_M2;
        end
        ST_M2: begin
          y_q     <= y_q - CW'(p_rnd);
          state_q <= ST_M3;
        end
        ST_M3: begin
          z_q     <= z_q - CW'(p_rnd);
          state_q <= ST_SQ0;
        end
        ST_SQ0: state_q <= ST_SQ1;
        ST_SQ1: begin
          sq_q    <= sq_q + p_u[SQ_W-1:0];
          state_q <= ST_SQ2;
        end
        ST_SQ2: begin
          sq_q    <= sq_q + p_u[SQ_W-1:0];
          state_q <= ST_SQ3;
        end
        ST_SQ3: begin
          sq_q    <= sq_q + p_u[SQ_W-1:0];
          sx_q    <= sx_q + SW'(x_q);
          sy_q    <= sy_q + SW'(y_q);
          sz_q    <= sz_q + SW'(z_q);
          cnt_q   <= cnt_q + CNTW'(1);
          state_q <= last_q ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (cnt_q == '0) begin
            quo_q   <= '0;
            emp_q   <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            emp_q   <= 1'b0;
            state_q <= ST_NQ0;
          end
        end
        ST_NQ0: state_q <= ST_NQ1;
        ST_NQ1: begin
          nq_q    <= WW'(p_u);
          state_q <= ST_NQ2;
        end
        ST_NQ2: begin
          nq_q    <= nq_q + (WW'(p_u) << 32);
          s2_q    <= '0;
          axis_q  <= AXIS_X;
          part_q  <= PART_LL;
          ppart_q <= PART_NONE;
          state_q <= ST_S2;
        end
        ST_S2: begin
          s2_q    <= s2_q + s2_add;
          ppart_q <= part_q;
          if (part_q == PART_HH) begin
            part_q <= PART_LL;
            axis_q <= axis_q + 2'd1;
            if (axis_q == AXIS_Z) begin
              state_q <= ST_S2E;
            end
          end else begin
            part_q <= part_q + 2'd1;
          end
        end
        ST_S2E: begin
          s2_q    <= s2_q + s2_add;
          state_q <= ST_DEN;
        end
        ST_DEN: state_q <= ST_DEN2;
        ST_DEN2: begin
          den_q   <= WW'(p_u) << 8;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (nq_q < s2_q) begin
            quo_q   <= '0;
            state_q <= ST_OUT;
          end else begin
            num_q   <= nq_q - s2_q;
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (num_q >= (den_q << RG_W)) begin
            quo_q   <= '1;
            state_q <= ST_OUT;
          end else begin
            quo_q   <= '0;
            dv_q    <= den_q << (RG_W - 1);
            bit_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (num_q >= dv_q) begin
            num_q <= num_q - dv_q;
            quo_q <= {quo_q[RG_W-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[RG_W-2:0], 1'b0};
          end
          dv_q  <= dv_q >> 1;
          bit_q <= bit_q + DIV_CNT_W'(1);
          if (bit_q == DIV_CNT_W'(RG_W - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_o   <= 1'b1;
            rg_squared_o  <= quo_q;
            point_count_o <= PC_W'(cnt_q);
            empty_res_o   <= emp_q;
            sx_q          <= '0;
            sy_q          <= '0;
            sz_q          <= '0;
            sq_q          <= '0;
            cnt_q         <= '0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The remainder stays below twice the shifted divisor during division
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> num_q < (dv_q << 1))
    else $error("divider remainder out of range");

  a_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SAT |-> num_q == nq_q - s2_q)
    else $error("numerator does not match its terms");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (cnt_q == '0 && sq_q == '0 && state_q == ST_IDLE))
    else $error("accumulators not cleared after a result");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

endmodule

`default_nettype wire

FILE: hw/rtl/membrane_collapsed_gyration_radius_core.sv
`default_nettype none

// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     coord_x/y/z, coord_valid, last
// out      output     out_valid_o / out_ready_i   rg_squared, point_count, empty_res
// cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// The back end handles one point at a time. With membrane collapse on, a point
// first passes the dot product, clamp and move states before its squares are
// summed; a skipped point that does not end a set is only popped. The final
// point of a set adds product terms and a divider that yields one quotient bit a cycle.
// The pace is set by the single shared 34x34 multiplier and the bit-serial divider.
// The front end takes a transaction whenever the two-entry queue has room.
// Reset is asynchronous and active low; no clearing pass is needed.
module membrane_collapsed_gyration_radius_core #(
  parameter int MAX_POINTS = 4096
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire signed [mcgr_pkg::CRD_W-1:0]      coord_x_i,
  input  wire signed [mcgr_pkg::CRD_W-1:0]      coord_y_i,
  input  wire signed [mcgr_pkg::CRD_W-1:0]      coord_z_i,
  input  wire                                   coord_valid_i,
  input  wire                                   last_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic [mcgr_pkg::RG_W-1:0]             rg_squared_o,
  output logic [mcgr_pkg::PC_W-1:0]             point_count_o,
  output logic                                  empty_res_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire [mcgr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [mcgr_pkg::CFG_DAT_W-1:0]         cfg_data_i
);
  import mcgr_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push, pop, q_full, q_empty;

  // Configuration writes are always taken; an index past the last register
  // is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{center_x: '0, center_y: '0, center_z: '0,
                 normal_x: '0, normal_y: '0, normal_z: NORMAL_Z_RESET,
                 core_thickness: '0, membrane_enable: 1'b0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CENTER_X:   cfg_q.center_x        <= cfg_data_i[CRD_W-1:0];
        REG_CENTER_Y:   cfg_q.center_y        <= cfg_data_i[CRD_W-1:0];
        REG_CENTER_Z:   cfg_q.center_z        <= cfg_data_i[CRD_W-1:0];
        REG_NORMAL_X:   cfg_q.normal_x        <= cfg_data_i[NRM_W-1:0];
        REG_NORMAL_Y:   cfg_q.normal_y        <= cfg_data_i[NRM_W-1:0];
        REG_NORMAL_Z:   cfg_q.normal_z        <= cfg_data_i[NRM_W-1:0];
        REG_THICKNESS:  cfg_q.core_thickness  <= cfg_data_i[THK_W-1:0];
        REG_MEM_ENABLE: cfg_q.membrane_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The front end classifies each point as accumulated or skipped, so the
  // back end never has to look at the point limit.
  mcgr_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .coord_valid_i (coord_valid_i),
    .last_i        (last_i),
    .full_i        (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  mcgr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  // The back end collapses, accumulates and, on the final point of a set,
  // works out the result into its own output register, so it carries on
  // with the next set while a result waits to be taken.
  mcgr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (q_empty),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rg_squared_o  (rg_squared_o),
    .point_count_o (point_count_o),
    .empty_res_o   (empty_res_o)
  );

endmodule

`default_nettype wire
